// ===== src/pcbe_pkg.sv =====
// shared types, constants and field widths for the bezier path evaluator
`timescale 1ns / 1ps
`default_nettype none

package pcbe_pkg;

    // field widths of the words on the channels
    localparam int OP_W   = 1;
    localparam int IDX_W  = 6;
    localparam int IO_W   = 32;
    localparam int POS_W  = 17;
    localparam int SEG_W  = 4;
    localparam int CNT_W  = 5;

    // fixed point
    localparam int FRAC_W = 16;
    localparam int WGT_W  = FRAC_W + 1;
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1 << FRAC_W);

    // parameter defaults
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_SQ_OM = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_U  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_W0    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_W1    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_W2    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_W3    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ACC2  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
    } t_blend_ctl;

endpackage

`default_nettype wire

// ===== src/pcbe_in_if.sv =====
// input channel: control point writes and evaluate requests
`timescale 1ns / 1ps
`default_nettype none

interface pcbe_in_if;
    logic                             valid;
    logic                             ready;
    logic [pcbe_pkg::OP_W-1:0]        operation;
    logic [pcbe_pkg::IDX_W-1:0]       point_index;
    logic signed [pcbe_pkg::IO_W-1:0] point_x;
    logic signed [pcbe_pkg::IO_W-1:0] point_y;
    logic signed [pcbe_pkg::IO_W-1:0] point_z;
    logic [pcbe_pkg::POS_W-1:0]       position;

    modport source (
        output valid, operation, point_index, point_x, point_y, point_z, position,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_x, point_y, point_z, position,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pcbe_out_if.sv =====
// output channel: evaluated path points
`timescale 1ns / 1ps
`default_nettype none

interface pcbe_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pcbe_pkg::IO_W-1:0] out_x;
    logic signed [pcbe_pkg::IO_W-1:0] out_y;
    logic signed [pcbe_pkg::IO_W-1:0] out_z;
    logic [pcbe_pkg::SEG_W-1:0]       segment_used;

    modport source (
        output valid, out_x, out_y, out_z, segment_used,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, segment_used,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pcbe_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pcbe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 49
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/pcbe_blend.sv =====
// three coordinate lanes: point times weight, floored, saturating accumulate
`timescale 1ns / 1ps
`default_nettype none

module pcbe_blend #(
    parameter int COORD_WIDTH = pcbe_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire pcbe_pkg::t_blend_ctl         i_ctl,
    input  wire logic [3*COORD_WIDTH-1:0]     i_point,
    input  wire logic [pcbe_pkg::WGT_W-1:0]   i_weight,
    output logic [3*COORD_WIDTH-1:0]          o_acc
);

    localparam int CW   = COORD_WIDTH;
    localparam int WS_W = pcbe_pkg::WGT_W + 1;
    localparam int PW   = CW + WS_W;
    localparam int FW   = pcbe_pkg::FRAC_W;
    localparam int TW   = PW - FW;
    localparam int SW   = TW + 1;

    logic signed [WS_W-1:0] weight_s;

    assign weight_s = $signed({1'b0, i_weight});

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [CW-1:0] pt;
        logic signed [PW-1:0] r_prod;
        logic signed [CW-1:0] r_acc;
        logic signed [TW-1:0] term;
        logic signed [CW-1:0] addend;
        logic signed [SW-1:0] sum;
        logic                 fits;
        logic signed [CW-1:0] sat;

        assign pt     = $signed(i_point[g*CW +: CW]);
        // low fraction bits dropped: arithmetic shift floors
        assign term   = $signed(r_prod[PW-1:FW]);
        assign addend = i_ctl.acc_first ? '0 : r_acc;
        assign sum    = SW'(term) + SW'(addend);
        assign fits   = (sum[SW-1:CW-1] == '0) || (sum[SW-1:CW-1] == '1);

        always_comb begin
            if (fits) begin
                sat = sum[CW-1:0];
            end else if (sum[SW-1]) begin
                sat = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat = {1'b0, {(CW-1){1'b1}}};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.mul_en) begin
                r_prod <= pt * weight_s;
            end
            if (i_ctl.acc_en) begin
                r_acc <= sat;
            end
        end

        assign o_acc[g*CW +: CW] = r_acc;
    end

endmodule

`default_nettype wire

// ===== src/piecewise_cubic_bezier_eval_unit.sv =====
// top level: control point store, weight sequencer and blend lanes
//
//  channel   dir  handshake          word
//  i_in      in   valid/ready        operation, point_index, point_x/y/z, position
//  o_out     out  valid/ready        out_x, out_y, out_z, segment_used
//  i_cfg     in   write enable only  segment_count
//
// a write word is taken and stored without leaving idle; an evaluate word runs from acceptance until
// its result sits in the output register: 8 sequencer steps, paced by the one shared
// weight multiplier (six products) and one store read per control point, plus a handoff.
// no new word is taken until the evaluation has left the handoff step.
// an evaluate word with zero segments is taken and gives no result.
// reset clears the segment count, the sequencer and the output valid; the store is not
// cleared. a result waits in the output register; while it is held the next result waits
// in the handoff step and no new word is taken.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_cubic_bezier_eval_unit #(
    parameter int MAX_SEGMENTS = pcbe_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = pcbe_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pcbe_pkg::CNT_W-1:0] i_cfg_wdata,
    pcbe_in_if.sink                         i_in,
    pcbe_out_if.source                      o_out
);

    localparam int NPOINTS = 3 * MAX_SEGMENTS + 1;
    localparam int AW      = $clog2(NPOINTS);
    localparam int CW      = COORD_WIDTH;
    localparam int RW      = 3 * CW;
    localparam int CNT_W   = pcbe_pkg::CNT_W;
    localparam int WGT_W   = pcbe_pkg::WGT_W;
    localparam int FW      = pcbe_pkg::FRAC_W;
    localparam int IO_W    = pcbe_pkg::IO_W;
    localparam int SEG_W   = pcbe_pkg::SEG_W;
    localparam int STEP_W  = pcbe_pkg::STEP_W;
    localparam int MB_W    = WGT_W + 1;
    localparam int MP_W    = WGT_W + MB_W;
    localparam int SC_W    = FW + CNT_W;

    // configuration
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] seg_eff;

    // sequencer
    pcbe_pkg::t_state     r_state, n_state;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 in_ready;
    logic                 out_free;
    logic                 load_out;
    pcbe_pkg::t_blend_ctl blend_ctl;

    // accepted word
    logic             in_acc;
    logic             wr_acc;
    logic             ev_start;
    logic [SC_W-1:0]  scaled;
    logic [CNT_W-1:0] k_in;
    logic [WGT_W-1:0] u_in;

    // weight unit
    logic [CNT_W-1:0]   r_k;
    logic [WGT_W-1:0]   r_u;
    logic [WGT_W-1:0]   r_om2;
    logic [WGT_W-1:0]   r_u2;
    logic [WGT_W-1:0]   r_w;
    logic [AW-1:0]      r_base;
    logic [CNT_W+1:0]   k_x3;
    logic [WGT_W-1:0]   om;
    logic [MB_W-1:0]    three_om;
    logic [MB_W-1:0]    three_om2;
    logic [WGT_W-1:0]   mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [MP_W-1:0]    mul_p;
    logic [WGT_W-1:0]   mul_q;

    // store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    // blend and output
    logic [RW-1:0]            blend_acc;
    logic signed [CW-1:0]     acc_x, acc_y, acc_z;
    logic                     r_out_valid;
    logic signed [IO_W-1:0]   r_out_x, r_out_y, r_out_z;
    logic [SEG_W-1:0]         r_out_seg;

    // ---------------------------------------------------------------- config
    assign seg_eff = (int'(r_cnt) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg_we) begin
            r_cnt <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- input side
    assign in_acc   = i_in.valid && in_ready;
    assign wr_acc   = in_acc && (i_in.operation == pcbe_pkg::OP_WRITE);
    assign ev_start = in_acc && (i_in.operation == pcbe_pkg::OP_EVAL) && (seg_eff != '0);

    // integer part picks the segment, fraction is the local parameter
    assign scaled = i_in.position[FW-1:0] * seg_eff;
    assign k_in   = i_in.position[FW] ? (seg_eff - CNT_W'(1)) : scaled[SC_W-1:FW];
    assign u_in   = i_in.position[FW] ? pcbe_pkg::ONE_Q16 : {1'b0, scaled[FW-1:0]};

    assign ram_we    = wr_acc && (int'(i_in.point_index) < NPOINTS);
    assign ram_waddr = AW'(i_in.point_index);
    assign ram_wdata = {CW'(i_in.point_z), CW'(i_in.point_y), CW'(i_in.point_x)};

    assign i_in.ready = in_ready;

    // ---------------------------------------------------------------- weights
    assign om        = pcbe_pkg::ONE_Q16 - r_u;
    assign three_om  = {1'b0, om} + {om, 1'b0};
    assign three_om2 = {1'b0, r_om2} + {r_om2, 1'b0};
    assign k_x3      = {2'b00, r_k} + {1'b0, r_k, 1'b0};

    always_comb begin
        case (r_step)
            pcbe_pkg::STEP_SQ_OM: begin
                mul_a = om;
                mul_b = {1'b0, om};
            end
            pcbe_pkg::STEP_SQ_U: begin
                mul_a = r_u;
                mul_b = {1'b0, r_u};
            end
            pcbe_pkg::STEP_W0: begin
                mul_a = om;
                mul_b = {1'b0, r_om2};
            end
            pcbe_pkg::STEP_W1: begin
                mul_a = r_u;
                mul_b = three_om2;
            end
            pcbe_pkg::STEP_W2: begin
                mul_a = r_u2;
                mul_b = three_om;
            end
            pcbe_pkg::STEP_W3: begin
                mul_a = r_u;
                mul_b = {1'b0, r_u2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    // every weight and square stays at or below one
    assign mul_q = mul_p[FW+WGT_W-1:FW];

    always_ff @(posedge i_clk) begin
        if (ev_start) begin
            r_k <= k_in;
            r_u <= u_in;
        end
        if (r_state == pcbe_pkg::ST_RUN) begin
            if (r_step == pcbe_pkg::STEP_SQ_OM) begin
                r_om2  <= mul_q;
                r_base <= AW'(k_x3);
            end
            if (r_step == pcbe_pkg::STEP_SQ_U) begin
                r_u2 <= mul_q;
            end
            if (r_step inside {[pcbe_pkg::STEP_W0:pcbe_pkg::STEP_W3]}) begin
                r_w <= mul_q;
            end
        end
    end

    // point i is read in the same step as weight i, both arrive together
    assign ram_raddr = r_base + AW'(r_step - pcbe_pkg::STEP_W0);

    // ---------------------------------------------------------------- sequencer
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            pcbe_pkg::ST_IDLE: begin
                if (ev_start) begin
                    n_state = pcbe_pkg::ST_RUN;
                end
            end
            pcbe_pkg::ST_RUN: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == pcbe_pkg::STEP_LAST) begin
                    n_state = pcbe_pkg::ST_FIN;
                end
            end
            pcbe_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = pcbe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready            = 1'b0;
        load_out            = 1'b0;
        blend_ctl.mul_en    = 1'b0;
        blend_ctl.acc_en    = 1'b0;
        blend_ctl.acc_first = 1'b0;
        case (r_state)
            pcbe_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            pcbe_pkg::ST_RUN: begin
                blend_ctl.mul_en    = r_step inside {[pcbe_pkg::STEP_W1:pcbe_pkg::STEP_ACC2]};
                blend_ctl.acc_en    = r_step inside {[pcbe_pkg::STEP_W2:pcbe_pkg::STEP_LAST]};
                blend_ctl.acc_first = (r_step == pcbe_pkg::STEP_W2);
            end
            pcbe_pkg::ST_FIN: begin
                load_out = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbe_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // ---------------------------------------------------------------- datapath
    pcbe_ram #(
        .WIDTH (RW),
        .DEPTH (NPOINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcbe_blend #(
        .COORD_WIDTH (CW)
    ) u_blend (
        .i_clk    (i_clk),
        .i_ctl    (blend_ctl),
        .i_point  (ram_rdata),
        .i_weight (r_w),
        .o_acc    (blend_acc)
    );

    assign acc_x = $signed(blend_acc[0*CW +: CW]);
    assign acc_y = $signed(blend_acc[1*CW +: CW]);
    assign acc_z = $signed(blend_acc[2*CW +: CW]);

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x   <= IO_W'(acc_x);
            r_out_y   <= IO_W'(acc_y);
            r_out_z   <= IO_W'(acc_z);
            r_out_seg <= r_k[SEG_W-1:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_x        = r_out_x;
    assign o_out.out_y        = r_out_y;
    assign o_out.out_z        = r_out_z;
    assign o_out.segment_used = r_out_seg;

endmodule

`default_nettype wire

// ===== src/pcbe_checker.sv =====
// port-level checks for the bezier path evaluator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pcbe_checker #(
    parameter int MAX_SEGMENTS = pcbe_pkg::MAX_SEGMENTS_DEF
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic [pcbe_pkg::OP_W-1:0]   i_in_op,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pcbe_pkg::IO_W-1:0]   i_out_x,
    input wire logic [pcbe_pkg::IO_W-1:0]   i_out_y,
    input wire logic [pcbe_pkg::IO_W-1:0]   i_out_z,
    input wire logic [pcbe_pkg::SEG_W-1:0]  i_out_seg
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_seg))
        else $error("result word changed while stalled");

    // a point write never makes the block busy
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == pcbe_pkg::OP_WRITE) |=> i_in_ready)
        else $error("block went busy after a point write");

    // a new result only follows a busy evaluation
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without an evaluation in flight");

    // segment index stays inside the path
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_SEGMENTS > 16) || (int'(i_out_seg) < MAX_SEGMENTS))
        else $error("segment index beyond the path");

endmodule

bind piecewise_cubic_bezier_eval_unit pcbe_checker #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
) u_pcbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_out_seg   (o_out.segment_used)
);

`default_nettype wire
